// ----- sv/lbc_pkg.sv -----
`timescale 1ns / 1ps
package lbc_pkg;
	localparam int Entries = 256;
	localparam int IdxW = $clog2(Entries);
	localparam int CntW = IdxW + 1;
	localparam int TagW = 32;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_PROM = 3'd3;
	localparam logic [2:0] ST_PLST = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;
	localparam logic [2:0] ST_CLR = 3'd6;

	typedef struct packed {
		logic          hit;
		logic [IdxW-1:0] found;
		logic [IdxW-1:0] found_rank;
		logic [IdxW-1:0] victim;
		logic [TagW-1:0] victim_tag;
	} scan_t;
endpackage

// ----- sv/lbc_ram.sv -----
`timescale 1ns / 1ps
module lbc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/lbc_scan.sv -----
`timescale 1ns / 1ps
module lbc_scan import lbc_pkg::*; (
	input  logic            clk,
	input  logic            start,
	input  logic            en,
	input  logic [TagW-1:0] blk,
	input  logic [IdxW-1:0] idx,
	input  logic [TagW-1:0] tag,
	input  logic [IdxW-1:0] rank,
	output scan_t           res
);
	scan_t r_q;
	scan_t nx;

	always_comb begin
		nx = start ? '0 : r_q;
		if (tag == blk && (!nx.hit || rank > nx.found_rank)) begin
			nx.hit = 1'b1;
			nx.found = idx;
			nx.found_rank = rank;
		end
		if (rank == '0) begin
			nx.victim = idx;
			nx.victim_tag = tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= nx;
		end
	end

	assign res = r_q;
endmodule

// ----- sv/lru_block_cache_lookup.sv -----
`timescale 1ns / 1ps
// each item is compared in one pass over the tag and rank memories, then a second
// pass ages the ranks and writes the new tag on a miss; in_stall stays high until the
// result is taken, so one item is handled at a time and a stalled result holds off
// the next item
// reset: a clearing pass writes tags to zero and ranks to the entry index, with
// in_stall high meanwhile; counts clear at once
module lru_block_cache_lookup import lbc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [31:0]     block_number,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            was_hit,
	output logic [31:0]     evicted_block,
	output logic [31:0]     hits_so_far,
	output logic [31:0]     misses_so_far
);
	logic [2:0] state_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] ridx_q;
	logic rvalid_q, rfirst_q;
	logic [TagW-1:0] blk_q;
	logic [31:0] hits_q, misses_q;
	logic [TagW-1:0] tag_rd;
	logic [IdxW-1:0] rank_rd;
	scan_t sres;
	logic tag_we, rank_we;
	logic [IdxW-1:0] tag_wa, rank_wa, rank_wd, raddr, sel, old_rank;
	logic [TagW-1:0] tag_wd;

	assign raddr = cnt_q[IdxW-1:0];
	assign sel = sres.hit ? sres.found : sres.victim;
	assign old_rank = sres.hit ? sres.found_rank : '0;

	lbc_ram #(.Width(TagW), .Depth(Entries)) u_tags (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(raddr), .rdata(tag_rd)
	);
	lbc_ram #(.Width(IdxW), .Depth(Entries)) u_ranks (
		.clk(clk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd),
		.raddr(raddr), .rdata(rank_rd)
	);
	lbc_scan u_scan (
		.clk(clk), .start(rfirst_q), .en(rvalid_q && state_q != ST_PROM
			&& state_q != ST_PLST),
		.blk(blk_q), .idx(ridx_q), .tag(tag_rd), .rank(rank_rd), .res(sres)
	);

	always_comb begin
		tag_we = 1'b0;
		tag_wa = raddr;
		tag_wd = '0;
		rank_we = 1'b0;
		rank_wa = raddr;
		rank_wd = raddr;
		unique case (state_q)
			ST_CLR: begin
				tag_we = 1'b1;
				rank_we = 1'b1;
			end
			ST_PROM, ST_PLST: begin
				rank_wa = ridx_q;
				if (rvalid_q) begin
					if (ridx_q == sel) begin
						rank_we = 1'b1;
						rank_wd = IdxW'(Entries - 1);
						tag_we = !sres.hit;
						tag_wa = ridx_q;
						tag_wd = blk_q;
					end else if (rank_rd > old_rank) begin
						rank_we = 1'b1;
						rank_wd = rank_rd - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q <= '0;
			rvalid_q <= 1'b0;
			rfirst_q <= 1'b0;
			ridx_q <= '0;
			hits_q <= '0;
			misses_q <= '0;
			out_valid <= 1'b0;
		end else begin
			rvalid_q <= 1'b0;
			rfirst_q <= 1'b0;
			ridx_q <= raddr;
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(Entries - 1)) begin
						state_q <= ST_IDLE;
						cnt_q <= '0;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						blk_q <= block_number;
						cnt_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rvalid_q <= 1'b1;
					rfirst_q <= cnt_q == '0;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(Entries - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					cnt_q <= '0;
					state_q <= ST_PROM;
				end
				ST_PROM: begin
					rvalid_q <= 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(Entries - 1)) begin
						state_q <= ST_PLST;
					end
				end
				ST_PLST: begin
					was_hit <= sres.hit;
					evicted_block <= sres.hit ? '0 : sres.victim_tag;
					hits_q <= hits_q + {31'd0, sres.hit};
					misses_q <= misses_q + {31'd0, !sres.hit};
					out_valid <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign hits_so_far = hits_q;
	assign misses_so_far = misses_q;
endmodule

// ----- sv/lbc_checker.sv -----
`timescale 1ns / 1ps
module lbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        was_hit,
	input logic [31:0] evicted_block,
	input logic [31:0] hits_so_far,
	input logic [31:0] misses_so_far
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hits_so_far))
		else $error("stalled result changed");
	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_hit |-> evicted_block == '0)
		else $error("evicted block on hit");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (hits_so_far != $past(hits_so_far)) !=
			(misses_so_far != $past(misses_so_far)))
		else $error("counts did not step by one item");
endmodule

bind lru_block_cache_lookup lbc_checker u_lbc_checker (.*);

// ----- verif/lru_block_cache_lookup_tb.sv -----
`timescale 1ns / 1ps
module lru_block_cache_lookup_tb;
	import lbc_pkg::*;

	typedef struct {
		logic        hit;
		logic [31:0] evicted;
		logic [31:0] hits;
		logic [31:0] misses;
	} lookup_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] block_number;
	logic        out_valid;
	logic        out_stall;
	logic        was_hit;
	logic [31:0] evicted_block;
	logic [31:0] hits_so_far;
	logic [31:0] misses_so_far;

	logic [31:0] model_tags [Entries];
	int unsigned model_rank [Entries];
	logic [31:0] model_hits;
	logic [31:0] model_misses;

	logic [31:0]    pending_blocks [$];
	lookup_result_t expected_results [$];
	logic [31:0]    block_pool [$];
	int             errors;
	int             burst_left;
	int             gap_left;
	int             hold_left;
	bit             long_hold_done;
	longint         cycle_count;

	lru_block_cache_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.block_number(block_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.was_hit(was_hit),
		.evicted_block(evicted_block),
		.hits_so_far(hits_so_far),
		.misses_so_far(misses_so_far)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void cache_reset();
		for (int i = 0; i < Entries; i++) begin
			model_tags[i] = '0;
			model_rank[i] = i;
		end
		model_hits = '0;
		model_misses = '0;
	endfunction

	function automatic void make_most_recent(int e);
		int unsigned old;
		old = model_rank[e];
		for (int i = 0; i < Entries; i++)
			if (model_rank[i] > old)
				model_rank[i] = model_rank[i] - 1;
		model_rank[e] = Entries - 1;
	endfunction

	function automatic lookup_result_t cache_lookup(logic [31:0] blk);
		lookup_result_t r;
		int found;
		int victim;
		bit hit;
		found = 0;
		victim = 0;
		hit = 0;
		r.evicted = '0;
		for (int i = 0; i < Entries; i++)
			if (model_tags[i] == blk && (!hit || model_rank[i] > model_rank[found])) begin
				found = i;
				hit = 1;
			end
		if (hit) begin
			model_hits = model_hits + 1;
			make_most_recent(found);
		end else begin
			model_misses = model_misses + 1;
			for (int i = 0; i < Entries; i++)
				if (model_rank[i] == 0)
					victim = i;
			r.evicted = model_tags[victim];
			model_tags[victim] = blk;
			make_most_recent(victim);
		end
		r.hit = hit;
		r.hits = model_hits;
		r.misses = model_misses;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			block_number <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(cache_lookup(block_number));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_blocks.size() > 0) begin
					in_valid <= 1'b1;
					block_number <= pending_blocks.pop_front();
					if (burst_left > 0)
						burst_left <= burst_left - 1;
					else begin
						burst_left <= $urandom_range(0, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0
							: $urandom_range(0, 600);
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left != 1);
		end else if (!long_hold_done && cycle_count > 20000) begin
			long_hold_done <= 1'b1;
			hold_left <= 4000;
			out_stall <= 1'b1;
		end else if (cycle_count[12]) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 200) == 0)
				hold_left <= $urandom_range(10, 700);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result hit=%0b evicted=%h", $time, was_hit,
					evicted_block);
				errors++;
			end else begin
				lookup_result_t e;
				e = expected_results.pop_front();
				if (was_hit !== e.hit) begin
					$display("%0t: was_hit expected %0b actual %0b", $time, e.hit, was_hit);
					errors++;
				end
				if (evicted_block !== e.evicted) begin
					$display("%0t: evicted_block expected %h actual %h", $time, e.evicted,
						evicted_block);
					errors++;
				end
				if (hits_so_far !== e.hits) begin
					$display("%0t: hits_so_far expected %0d actual %0d", $time, e.hits,
						hits_so_far);
					errors++;
				end
				if (misses_so_far !== e.misses) begin
					$display("%0t: misses_so_far expected %0d actual %0d", $time, e.misses,
						misses_so_far);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 10000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [31:0] pick_block();
		int k;
		logic [31:0] b;
		k = $urandom_range(0, 9);
		if (k < 6 && block_pool.size() > 0)
			b = block_pool[$urandom_range(0, block_pool.size() - 1)];
		else if (k == 6)
			b = $urandom_range(0, 3);
		else
			b = $urandom();
		if (block_pool.size() < 300)
			block_pool.push_back(b);
		else
			block_pool[$urandom_range(0, 299)] = b;
		return b;
	endfunction

	initial begin
		errors = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		cache_reset();
		// block 0 hits on reset contents, extremes, then misses and hits
		pending_blocks.push_back(32'h0);
		pending_blocks.push_back(32'h0);
		pending_blocks.push_back(32'hFFFF_FFFF);
		pending_blocks.push_back(32'hFFFF_FFFF);
		pending_blocks.push_back(32'h8000_0000);
		pending_blocks.push_back(32'h0000_0001);
		pending_blocks.push_back(32'h5555_5555);
		pending_blocks.push_back(32'hAAAA_AAAA);
		pending_blocks.push_back(32'h0);
		pending_blocks.push_back(32'h8000_0000);
		pending_blocks.push_back(32'h0000_0001);
		pending_blocks.push_back(32'h7FFF_FFFF);
		pending_blocks.push_back(32'h0);
		pending_blocks.push_back(32'hFFFF_FFFF);
		// fill past capacity so reset zeros are all evicted
		for (int i = 0; i < 270; i++)
			pending_blocks.push_back(32'h1000 + i);
		pending_blocks.push_back(32'h0);
		pending_blocks.push_back(32'h1000);
		pending_blocks.push_back(32'h1000 + 269);
		for (int i = 0; i < 410; i++)
			pending_blocks.push_back(pick_block());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_blocks.size() == 0);
		@(posedge clk);
		while (in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (2 * Entries + 20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/lbc_pkg.sv
sv/lbc_ram.sv
sv/lbc_scan.sv
sv/lru_block_cache_lookup.sv
sv/lbc_checker.sv
verif/lru_block_cache_lookup_tb.sv
